[rtl/pgmap_pkg.sv]
// ----------------------------------------------------------------------------
// pgmap_pkg
// Shared constants, codes and controller/datapath interface types for the
// four-level page table mapper.
// ----------------------------------------------------------------------------
package pgmap_pkg;

  // Table store geometry
  localparam int TABLE_SLOTS       = 64;
  localparam int IDX_W             = 9;
  localparam int ENTRIES_PER_TABLE = 1 << IDX_W;
  localparam int SLOT_W            = $clog2(TABLE_SLOTS);
  localparam int ADDR_W            = SLOT_W + IDX_W;
  localparam int STORE_DEPTH       = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int CNT_W             = $clog2(TABLE_SLOTS + 1);
  localparam int ENTRY_W           = 64;
  localparam int PAGE_SHIFT        = 12;
  localparam int FRAME_W           = ENTRY_W - PAGE_SHIFT;

  // Field widths
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int FLAG_W   = 12;
  localparam int BASE_W   = 40;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int MADE_W   = 2;
  localparam int LEVEL_W  = 2;

  // Stream and config port widths
  localparam int IN_W      = 112;
  localparam int OUT_W     = 56;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 40;

  // Entry attribute bits of a freshly linked table: present, writable, user
  localparam logic [PAGE_SHIFT-1:0] TABLE_ATTR = 12'h007;

  // Walk levels; the leaf level selects the lowest index
  localparam logic [LEVEL_W-1:0] LEVEL_TOP        = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LAST_TABLE = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_LEAF       = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_BASE = 1'b0,
    CFG_SLOT_LIMIT = 1'b1
  } cfg_reg_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    MAP_OK      = 2'd0,
    MAP_NO_SLOT = 2'd1,
    MAP_OUTSIDE = 2'd2
  } map_status_t;

  // Controller to datapath
  typedef struct packed {
    logic               clear;     // zero one store entry
    logic               accept;    // capture request
    logic               read;      // issue table read
    logic               walk;      // evaluate entry, allocate if needed
    logic               leaf;      // write leaf entry
    logic               load_out;  // load result register
    logic [LEVEL_W-1:0] level;
  } pgmap_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // last entry of clearing pass
    logic stop;        // walk ends with an error
  } pgmap_sts_t;

endpackage

[rtl/pgmap_ram.sv]
// ----------------------------------------------------------------------------
// pgmap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgmap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/pgmap_dp.sv]
// ----------------------------------------------------------------------------
// pgmap_dp
// Mapper datapath: config registers, request registers, table store,
// allocator, frame range check and result register.
// ----------------------------------------------------------------------------
module pgmap_dp
  import pgmap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  pgmap_cmd_t           cmd,
  output pgmap_sts_t           sts,
  input  logic [IN_W-1:0]      in_data,
  output logic [OUT_W-1:0]     out_data,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Config registers
  logic [BASE_W-1:0]  base;
  logic [LIMIT_W-1:0] limit;

  // Control state
  logic [ADDR_W-1:0]  clr_cnt;
  logic [CNT_W-1:0]   nfs;

  // Request and walk registers
  logic [VA_W-1:0]     va;
  logic [PA_W-1:0]     pa;
  logic [FLAG_W-1:0]   fl;
  logic [SLOT_W-1:0]   slot;
  logic [MADE_W-1:0]   made;
  map_status_t         status;

  // Result register
  map_status_t         out_status;
  logic [MADE_W-1:0]   out_made;
  logic [PA_W-1:0]     out_leaf;

  // Combinational
  logic [IDX_W-1:0]    idx_sel;
  logic [ADDR_W-1:0]   addr;
  logic [ENTRY_W-1:0]  rd_entry;
  logic                present;
  logic [FRAME_W:0]    diff;
  logic                outside;
  logic [CNT_W-1:0]    eff_lim;
  logic                exhausted;
  logic                alloc;
  logic [BASE_W:0]     new_frame;
  logic [ENTRY_W-1:0]  ptr_entry;
  logic [PA_W-1:0]     leaf_val;
  logic                ram_wen;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;

  // Index of the current level
  always_comb begin
    case (cmd.level)
      2'd0:    idx_sel = va[PAGE_SHIFT + 3*IDX_W +: IDX_W];
      2'd1:    idx_sel = va[PAGE_SHIFT + 2*IDX_W +: IDX_W];
      2'd2:    idx_sel = va[PAGE_SHIFT + IDX_W +: IDX_W];
      default: idx_sel = va[PAGE_SHIFT +: IDX_W];
    endcase
  end

  assign addr = {slot, idx_sel};

  // Present entry: frame must fall inside the store
  assign present = rd_entry[0];
  assign diff    = {1'b0, rd_entry[ENTRY_W-1:PAGE_SHIFT]}
                 - {{(FRAME_W + 1 - BASE_W){1'b0}}, base};
  assign outside = (diff >= (FRAME_W + 1)'(TABLE_SLOTS));

  // Effective slot limit, clamped to one..TABLE_SLOTS
  always_comb begin
    if (limit == '0) begin
      eff_lim = CNT_W'(1);
    end else if (32'(limit) > 32'(TABLE_SLOTS)) begin
      eff_lim = CNT_W'(TABLE_SLOTS);
    end else begin
      eff_lim = CNT_W'(limit);
    end
  end

  assign exhausted = (nfs >= eff_lim);
  assign alloc     = cmd.walk && !present && !exhausted;
  assign sts.stop  = present ? outside : exhausted;
  assign sts.clear_last = (clr_cnt == ADDR_W'(STORE_DEPTH - 1));

  // Entries to write
  assign new_frame = {1'b0, base} + (BASE_W + 1)'(nfs);
  assign ptr_entry = {{(ENTRY_W - BASE_W - 1 - PAGE_SHIFT){1'b0}}, new_frame, TABLE_ATTR};
  assign leaf_val  = pa | {{(PA_W - FLAG_W){1'b0}}, fl};

  // Store write arbitration
  always_comb begin
    ram_wen   = cmd.clear || alloc || cmd.leaf;
    ram_waddr = cmd.clear ? clr_cnt : addr;
    if (cmd.clear) begin
      ram_wdata = '0;
    end else if (cmd.leaf) begin
      ram_wdata = {{(ENTRY_W - PA_W){1'b0}}, leaf_val};
    end else begin
      ram_wdata = ptr_entry;
    end
  end

  pgmap_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .ren   (cmd.read),
    .raddr (addr),
    .rdata (rd_entry)
  );

  // Config, clear counter and allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= '0;
      limit   <= LIMIT_W'(64);
      clr_cnt <= '0;
      nfs     <= CNT_W'(1);
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_TABLE_BASE: base  <= cfg_data[BASE_W-1:0];
          CFG_SLOT_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (alloc) begin
        nfs <= nfs + CNT_W'(1);
      end
    end
  end

  // Request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      va     <= in_data[VA_W-1:0];
      pa     <= in_data[VA_W +: PA_W];
      fl     <= in_data[VA_W + PA_W +: FLAG_W];
      slot   <= '0;
      made   <= '0;
      status <= MAP_OK;
    end else if (cmd.walk) begin
      if (present) begin
        if (outside) begin
          status <= MAP_OUTSIDE;
        end else begin
          slot <= diff[SLOT_W-1:0];
        end
      end else if (exhausted) begin
        status <= MAP_NO_SLOT;
      end else begin
        slot <= nfs[SLOT_W-1:0];
        made <= made + MADE_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= status;
      out_made   <= made;
      out_leaf   <= (status == MAP_OK) ? leaf_val : '0;
    end
  end

  assign out_data = {out_leaf, out_made, out_status};

  // Allocator never runs past the store
  a_nfs_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nfs) <= 32'(TABLE_SLOTS))
    else $error("allocator past store size");

  // Allocator only moves forward between resets
  a_nfs_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> nfs >= $past(nfs))
    else $error("allocator moved backward");

endmodule

[rtl/pgmap_ctrl.sv]
// ----------------------------------------------------------------------------
// pgmap_ctrl
// Mapper controller: clearing pass, table walk sequencing and output valid.
// ----------------------------------------------------------------------------
module pgmap_ctrl
  import pgmap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output pgmap_cmd_t cmd,
  input  pgmap_sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_LEAF,
    ST_DONE
  } state_t;

  state_t             state;
  logic [LEVEL_W-1:0] level;

  assign s_tready = (state == ST_IDLE);

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.level    = level;
    case (state)
      ST_CLEAR: cmd.clear    = 1'b1;
      ST_IDLE:  cmd.accept   = s_tvalid;
      ST_READ:  cmd.read     = 1'b1;
      ST_EVAL:  cmd.walk     = 1'b1;
      ST_LEAF:  cmd.leaf     = 1'b1;
      ST_DONE:  cmd.load_out = !m_tvalid || m_tready;
      default:  ;
    endcase
  end

  // State, level and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      level    <= LEVEL_TOP;
      m_tvalid <= 1'b0;
    end else begin
      // Output valid: set by a result load, cleared by a transfer out
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (sts.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            level <= LEVEL_TOP;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_EVAL;
        ST_EVAL: begin
          if (sts.stop) begin
            state <= ST_DONE;
          end else if (level == LEVEL_LAST_TABLE) begin
            level <= LEVEL_LEAF;
            state <= ST_LEAF;
          end else begin
            level <= level + LEVEL_W'(1);
            state <= ST_READ;
          end
        end
        ST_LEAF: state <= ST_DONE;
        ST_DONE: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A transfer in starts a walk
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_READ && level == LEVEL_TOP)
    else $error("accepted request did not start walk");

  // Entry evaluation always follows a read, covering RAM latency
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> $past(state) == ST_READ)
    else $error("evaluate without read");

  // No result during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !m_tvalid)
    else $error("result during clearing pass");

endmodule

[rtl/four_level_page_table_mapper_top.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_top
// Maps one virtual page per request into a four-level table store.
// ----------------------------------------------------------------------------
// After reset the block zeroes its whole table store, one entry per cycle,
// with s_tready low; config writes are taken throughout. A request then
// walks the three upper levels, each as a registered store read followed
// by a check or allocation of the entry, and writes the leaf. s_tready
// stays low from a request's transfer in until its result is loaded; a walk
// that stops at upper level k (0..2) skips the leaf write. The result sits
// in an output register, so the next request is taken while it waits; the
// final state of a walk is held for as long as the previous result has not
// yet been transferred out. Config is to be written only while the block
// is idle; the user must keep to this, as the block itself does not enforce it.
module four_level_page_table_mapper_top
  import pgmap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,  // virt_addr[47:0], phys_addr[99:48], page_flags[111:100]
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,  // status[1:0], tables_made[3:2], leaf_value[55:4]
  // Config write port
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pgmap_cmd_t cmd;
  pgmap_sts_t sts;

  pgmap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pgmap_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
